// ----- rtl/crf_pkg.sv -----
`timescale 1ns / 1ps

package crf_pkg;

    localparam int BUF_DEPTH = 4096;
    // depth in use: positions must fit in 12 bits
    localparam int EFF_DEPTH = (BUF_DEPTH > 4096) ? 4096 : ((BUF_DEPTH < 1) ? 1 : BUF_DEPTH);
    localparam logic [11:0] LAST_POS = 12'(EFF_DEPTH - 1);

    localparam logic [7:0] HDR_BYTE     = 8'h76;
    localparam logic [7:0] CMD_BAUD     = 8'h24;
    localparam logic [7:0] CMD_SIZE     = 8'h31;
    localparam logic [7:0] CMD_PHOTO    = 8'h36;
    localparam logic [7:0] CMD_RESET    = 8'h26;
    localparam logic [7:0] CMD_JPEG_LEN = 8'h34;
    localparam logic [7:0] CMD_JPEG     = 8'h32;
    localparam logic [7:0] JPEG_MARK    = 8'hFF;
    localparam logic [7:0] JPEG_END     = 8'hD9;

    localparam logic [6:0] SPAN_SHORT    = 7'd4;
    localparam logic [6:0] SPAN_RESET    = 7'd69;
    localparam logic [6:0] SPAN_JPEG_LEN = 7'd8;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_REARM = 1'b1;

    typedef struct packed {
        logic [7:0]  prev_byte;
        logic [7:0]  prev_prev_byte;
        logic [11:0] byte_count;
        logic [6:0]  expected_span;
        logic        jpeg_mode;
        logic [11:0] header_pos;
        logic        reply_done;
    } crf_state_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] position;
        logic        frame_last;
        logic [12:0] frame_length;
        logic        dropped;
        logic        overflow;
    } crf_result_t;

endpackage

// ----- rtl/crf_core.sv -----
`timescale 1ns / 1ps

module crf_core
    import crf_pkg::*;
(
    input  crf_state_t  state,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output crf_state_t  state_next,
    output crf_result_t result,
    output logic        has_result
);

    logic [11:0] pos;
    logic [11:0] span_dist;
    logic        finish;
    logic        ovf;

    assign pos       = state.byte_count;
    assign span_dist = pos - state.header_pos;

    always_comb
    begin
        state_next        = state;
        result            = '0;
        result.data_byte  = rx_byte;
        has_result        = 1'b1;
        finish            = 1'b0;
        ovf               = 1'b0;

        if (op == OP_REARM)
        begin
            state_next = '0;
            has_result = 1'b0;
        end
        else if (state.reply_done)
        begin
            result.dropped = 1'b1;
        end
        else
        begin
            result.position = pos;
            if (state.expected_span == 7'd0 && !state.jpeg_mode)
            begin
                // header search: command byte sits two places after 0x76
                if (pos >= 12'd2 && state.prev_prev_byte == HDR_BYTE)
                begin
                    if (rx_byte inside {CMD_BAUD, CMD_SIZE, CMD_PHOTO})
                        state_next.expected_span = SPAN_SHORT;
                    else if (rx_byte == CMD_RESET)
                        state_next.expected_span = SPAN_RESET;
                    else if (rx_byte == CMD_JPEG_LEN)
                        state_next.expected_span = SPAN_JPEG_LEN;
                    else if (rx_byte == CMD_JPEG)
                        state_next.jpeg_mode = 1'b1;
                    state_next.header_pos = pos - 12'd2;
                end
            end
            else if (state.expected_span != 7'd0 && span_dist >= {5'd0, state.expected_span})
            begin
                finish = 1'b1;
            end
            else if (state.expected_span == 7'd0 && state.jpeg_mode &&
                     state.prev_byte == JPEG_MARK && rx_byte == JPEG_END)
            begin
                finish = 1'b1;
            end

            if (!finish && pos >= LAST_POS)
            begin
                finish = 1'b1;
                ovf    = 1'b1;
            end

            state_next.prev_prev_byte = state.prev_byte;
            state_next.prev_byte      = rx_byte;

            if (finish)
            begin
                result.frame_last    = 1'b1;
                result.frame_length  = {1'b0, pos} + 13'd1;
                result.overflow      = ovf;
                state_next.reply_done = 1'b1;
                state_next.byte_count = 12'd0;
            end
            else
            begin
                state_next.byte_count = pos + 12'd1;
            end
        end
    end

endmodule

// ----- rtl/camera_response_framer_top.sv -----
`timescale 1ns / 1ps
// a beat goes from the input register through the result register to the master side
// throughput: one beat per cycle while the master side takes results; the framing state
// updates as an item leaves the input register; a stalled master side holds byte beats there
// rearm beats produce no result; reset clears all framing state and both registers' valid flags
// reset: rst_n asynchronous, active low

module camera_response_framer_top
    import crf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] data_byte, [19:8] position, [32:20] frame_length
    output logic        m_tlast,   // frame_last
    output logic [1:0]  m_tuser    // [0] dropped, [1] overflow
);

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        out_free;

    crf_state_t  state_reg;
    crf_state_t  state_next;
    crf_result_t result;
    logic        has_result;

    logic        out_valid_reg;
    logic        out_valid_next;
    crf_result_t out_reg;

    assign out_free = !out_valid_reg || m_tready;
    // a rearm beat leaves without needing the result register
    assign advance  = in_valid_reg && (in_op_reg == OP_REARM || out_free);
    assign s_tready = !in_valid_reg || advance;

    crf_core u_core (
        .state      (state_reg),
        .op         (in_op_reg),
        .rx_byte    (in_byte_reg),
        .state_next (state_next),
        .result     (result),
        .has_result (has_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (advance && has_result)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_op_reg     <= OP_BYTE;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                in_op_reg    <= s_tuser;
            end
            if (advance)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (advance && has_result)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.frame_length, out_reg.position, out_reg.data_byte};
    assign m_tlast  = out_reg.frame_last;
    assign m_tuser  = {out_reg.overflow, out_reg.dropped};

endmodule

// ----- tb/camera_response_framer_top_test.sv -----
`timescale 1ns / 1ps

module camera_response_framer_top_test
    import crf_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 235;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        s_tuser  = OP_BYTE; // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [7:0] data_byte, [19:8] position, [32:20] frame_length
    logic        m_tlast;            // frame_last
    logic [1:0]  m_tuser;            // [0] dropped, [1] overflow

    camera_response_framer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    typedef struct {
        logic        op;
        logic [7:0]  rx;
        bit          typed;
        crf_result_t want;
    } stim_row_t;

    stim_row_t   directed_rows [28];
    crf_result_t predicted_echoes [$];
    logic [7:0]  cmd_set [6] = '{CMD_BAUD, CMD_SIZE, CMD_PHOTO, CMD_RESET, CMD_JPEG_LEN, CMD_JPEG};

    // framing state of the predictor
    logic [7:0]  fr_prev;
    logic [7:0]  fr_prev2;
    logic [11:0] fr_count;
    logic [6:0]  fr_span;
    logic        fr_jpeg;
    logic [11:0] fr_hdr_pos;
    logic        fr_done;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int live_items    = 0;
    int errors        = 0;
    int idle_cycles   = 0;
    int n_bytes       = 0;
    int n_rearms      = 0;
    int n_frames      = 0;
    int n_overflows   = 0;
    int n_dropped     = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_framing();
        fr_prev    = '0;
        fr_prev2   = '0;
        fr_count   = '0;
        fr_span    = '0;
        fr_jpeg    = 1'b0;
        fr_hdr_pos = '0;
        fr_done    = 1'b0;
    endfunction

    // advances the framing state by one item; returns 1 when a beat comes out
    function automatic bit frame_byte(input logic op, input logic [7:0] rx,
                                      output crf_result_t r);
        logic [11:0] pos;
        logic        finish;
        logic        ovf;
        r      = '0;
        pos    = fr_count;
        finish = 1'b0;
        ovf    = 1'b0;
        if (op == OP_REARM)
        begin
            clear_framing();
            return 1'b0;
        end
        r.data_byte = rx;
        if (fr_done)
        begin
            r.dropped = 1'b1;
            return 1'b1;
        end
        r.position = pos;
        if (fr_span == '0 && !fr_jpeg)
        begin
            if (pos >= 12'd2 && fr_prev2 == HDR_BYTE)
            begin
                case (rx)
                    CMD_BAUD, CMD_SIZE, CMD_PHOTO: fr_span = SPAN_SHORT;
                    CMD_RESET:                     fr_span = SPAN_RESET;
                    CMD_JPEG_LEN:                  fr_span = SPAN_JPEG_LEN;
                    CMD_JPEG:                      fr_jpeg = 1'b1;
                    default: ;
                endcase
                fr_hdr_pos = pos - 12'd2;
            end
        end
        else if (fr_span != '0 && (pos - fr_hdr_pos) >= {5'd0, fr_span})
            finish = 1'b1;
        else if (fr_span == '0 && fr_jpeg && fr_prev == JPEG_MARK && rx == JPEG_END)
            finish = 1'b1;
        if (!finish && pos >= LAST_POS)
        begin
            finish = 1'b1;
            ovf    = 1'b1;
        end
        fr_prev2 = fr_prev;
        fr_prev  = rx;
        if (finish)
        begin
            r.frame_last   = 1'b1;
            r.frame_length = {1'b0, pos} + 13'd1;
            r.overflow     = ovf;
            fr_done        = 1'b1;
            fr_count       = '0;
        end
        else
            fr_count = pos + 12'd1;
        return 1'b1;
    endfunction

    task automatic put_beat(input logic op, input logic [7:0] rx,
                            input bit typed = 1'b0, input crf_result_t want = '0);
        crf_result_t predicted;
        bit          has_beat;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        has_beat = frame_byte(op, rx, predicted);
        if (has_beat)
            predicted_echoes.push_back(typed ? want : predicted);
        if (!(has_beat && predicted.dropped))
            live_items++;
        if (op == OP_REARM)
            n_rearms++;
        else
            n_bytes++;
    endtask

    // mostly well-formed replies with random content, some noise and cut-short replies
    task automatic send_reply();
        int         sel;
        int         body;
        logic [7:0] cmd;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                put_beat(($urandom_range(7) == 0) ? OP_REARM : OP_BYTE, 8'($urandom));
            return;
        end
        put_beat(OP_REARM, 8'($urandom));
        repeat ($urandom_range(0, 3))
            put_beat(OP_BYTE, 8'($urandom));
        put_beat(OP_BYTE, HDR_BYTE);
        put_beat(OP_BYTE, 8'($urandom));
        sel = $urandom_range(0, 6);
        cmd = (sel == 6) ? 8'($urandom) : cmd_set[sel];
        put_beat(OP_BYTE, cmd);
        case (cmd)
            CMD_BAUD, CMD_SIZE, CMD_PHOTO: body = SPAN_SHORT - 2;
            CMD_RESET:                     body = SPAN_RESET - 2;
            CMD_JPEG_LEN:                  body = SPAN_JPEG_LEN - 2;
            default:                       body = 12;
        endcase
        if (cmd == CMD_JPEG)
        begin
            repeat ($urandom_range(0, 24))
                put_beat(OP_BYTE, 8'($urandom));
            put_beat(OP_BYTE, JPEG_MARK);
            put_beat(OP_BYTE, JPEG_END);
        end
        else
        begin
            if ($urandom_range(7) == 0)
                body = $urandom_range(0, body);
            repeat (body)
                put_beat(OP_BYTE, 8'($urandom));
        end
        repeat ($urandom_range(0, 2))
            put_beat(OP_BYTE, 8'($urandom));
    endtask

    task automatic compare_field(input string label, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        crf_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_echoes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, got data %0h", $time,
                         m_tdata[7:0]);
            end
            else
            begin
                want = predicted_echoes.pop_front();
                compare_field("data_byte", want.data_byte, m_tdata[7:0]);
                compare_field("position", want.position, m_tdata[19:8]);
                compare_field("frame_last", want.frame_last, m_tlast);
                compare_field("frame_length", want.frame_length, m_tdata[32:20]);
                compare_field("dropped", want.dropped, m_tuser[0]);
                compare_field("overflow", want.overflow, m_tuser[1]);
            end
            n_frames    += m_tlast;
            n_overflows += m_tuser[1];
            n_dropped   += m_tuser[0];
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
                     WATCHDOG_LIMIT, predicted_echoes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        directed_rows = '{
            '{OP_BYTE,  8'h00,        1'b1, '{8'h00, 12'd0, 1'b0, 13'd0, 1'b0, 1'b0}},
            '{OP_BYTE,  CMD_BAUD,     1'b0, '0},
            '{OP_BYTE,  HDR_BYTE,     1'b0, '0},
            '{OP_BYTE,  8'h00,        1'b0, '0},
            '{OP_BYTE,  CMD_BAUD,     1'b0, '0},
            '{OP_BYTE,  8'h80,        1'b0, '0},
            '{OP_BYTE,  8'h01,        1'b1, '{8'h01, 12'd6, 1'b1, 13'd7, 1'b0, 1'b0}},
            '{OP_BYTE,  8'hFF,        1'b1, '{8'hFF, 12'd0, 1'b0, 13'd0, 1'b1, 1'b0}},
            '{OP_REARM, 8'hFF,        1'b0, '0},
            '{OP_BYTE,  JPEG_END,     1'b0, '0},
            '{OP_BYTE,  HDR_BYTE,     1'b0, '0},
            '{OP_BYTE,  8'h5A,        1'b0, '0},
            '{OP_BYTE,  CMD_JPEG,     1'b0, '0},
            '{OP_BYTE,  JPEG_END,     1'b0, '0},
            '{OP_BYTE,  JPEG_MARK,    1'b0, '0},
            '{OP_BYTE,  JPEG_END,     1'b1, '{JPEG_END, 12'd6, 1'b1, 13'd7, 1'b0, 1'b0}},
            '{OP_REARM, 8'h00,        1'b0, '0},
            '{OP_BYTE,  HDR_BYTE,     1'b0, '0},
            '{OP_BYTE,  8'h00,        1'b0, '0},
            '{OP_BYTE,  8'h99,        1'b0, '0},
            '{OP_BYTE,  HDR_BYTE,     1'b0, '0},
            '{OP_BYTE,  8'h7F,        1'b0, '0},
            '{OP_BYTE,  CMD_RESET,    1'b0, '0},
            '{OP_REARM, 8'hA5,        1'b0, '0},
            '{OP_BYTE,  HDR_BYTE,     1'b0, '0},
            '{OP_BYTE,  8'hFF,        1'b0, '0},
            '{OP_BYTE,  CMD_JPEG_LEN, 1'b0, '0},
            '{OP_REARM, 8'h5A,        1'b0, '0}
        };
        clear_framing();
        send_idle_pct = 15;
        recv_idle_pct = 85;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            put_beat(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].typed,
                     directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : ((phase == 1) ? 85 : 0);
            recv_idle_pct = (phase == 0) ? 85 : ((phase == 1) ? 15 : 0);
            while (live_items < PHASE_ITEMS * (phase + 1))
                send_reply();
        end

        s_tvalid <= 1'b0;
        while (predicted_echoes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d byte beats and %0d rearms under three idling mixes", n_bytes,
                 n_rearms);
        $display("saw %0d completed replies, %0d ended by buffer overflow, %0d dropped beats",
                 n_frames, n_overflows, n_dropped);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/crf_pkg.sv
rtl/crf_core.sv
rtl/camera_response_framer_top.sv
tb/camera_response_framer_top_test.sv
